[rtl/core/gdfw_pkg.sv]
package gdfw_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned NODE_SLOTS_DEF   = 256;

  localparam int unsigned VTX_W = 5;   // vertex field width
  localparam int unsigned CFG_W = 6;   // vertex_count register width
  localparam int unsigned CNT_W = 7;   // clamped vertex count, at most MAX_VERTICES

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 6'd32;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    RS_VISIT      = 3'd0,
    RS_EDGE_ADDED = 3'd1,
    RS_FULL       = 3'd2,
    RS_BAD_VERTEX = 3'd3,
    RS_CLEARED    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    status_e          status;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD2,
    S_WALK,
    S_FETCH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_BAD,
    OP_FULL,
    OP_ADD_A,
    OP_ADD_B,
    OP_VISIT_START,
    OP_POP,
    OP_READ,
    OP_STEP,
    OP_FINISH
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad_a;
    logic       bad_ab;
    logic       full;
    logic       level_zero;
    logic       cur_ok;
  } stat_t;

endpackage

[rtl/core/graph_depth_first_walk_unit.sv]
// depth-first walk over an undirected graph held as adjacency lists in a node ram. a command
// is taken when start is high and busy is low; every result shows on res_o for exactly one
// cycle with res_valid_o high, and the receiver cannot stall, so results must be taken as
// they come. during a search each stored list node in the walked lists costs one ram read
// and one evaluation, and each visited vertex has its frame popped; one search result lags
// one visit so that the final visit carries last. vertex_count may only be written while idle.
module graph_depth_first_walk_unit #(
  parameter int unsigned MAX_VERTICES = gdfw_pkg::MAX_VERTICES_DEF,
  parameter int unsigned NODE_SLOTS   = gdfw_pkg::NODE_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command transfer
  input  logic                       start,
  output logic                       busy,
  input  gdfw_pkg::cmd_t             cmd_i,
  // vertex_count register write
  input  logic                       cfg_we_i,
  input  logic [gdfw_pkg::CFG_W-1:0] cfg_wdata_i,
  // result transfer
  output logic                       res_valid_o,
  output gdfw_pkg::res_t             res_o
);

  gdfw_pkg::ctrl_t ctrl;
  gdfw_pkg::stat_t stat;

  // sequencer: decode, second half of an add, walk loop
  gdfw_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  // list heads, node ram, visited marks, cursor stack and result register
  gdfw_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .NODE_SLOTS  (NODE_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

[rtl/core/gdfw_ram.sv]
module gdfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gdfw_ctrl.sv]
module gdfw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  gdfw_pkg::stat_t stat_i,
  output gdfw_pkg::ctrl_t ctrl_o
);

  gdfw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdfw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdfw_pkg::S_IDLE: begin
        if (start) state_d = gdfw_pkg::S_DECODE;
      end
      gdfw_pkg::S_DECODE: begin
        state_d = gdfw_pkg::S_IDLE;
        if (stat_i.cmd == gdfw_pkg::CMD_ADD && !stat_i.bad_ab && !stat_i.full) begin
          state_d = gdfw_pkg::S_ADD2;
        end else if (stat_i.cmd == gdfw_pkg::CMD_SEARCH && !stat_i.bad_a) begin
          state_d = gdfw_pkg::S_WALK;
        end
      end
      gdfw_pkg::S_ADD2: state_d = gdfw_pkg::S_IDLE;
      gdfw_pkg::S_WALK: begin
        if (stat_i.level_zero) state_d = gdfw_pkg::S_IDLE;
        else if (stat_i.cur_ok) state_d = gdfw_pkg::S_FETCH;
      end
      gdfw_pkg::S_FETCH: state_d = gdfw_pkg::S_WALK;
      default: state_d = gdfw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.load = 1'b0;
    ctrl_o.op   = gdfw_pkg::OP_NONE;
    unique case (state_q)
      gdfw_pkg::S_IDLE: ctrl_o.load = start;
      gdfw_pkg::S_DECODE: begin
        unique case (stat_i.cmd)
          gdfw_pkg::CMD_CLEAR: ctrl_o.op = gdfw_pkg::OP_CLEAR;
          gdfw_pkg::CMD_ADD: begin
            if (stat_i.bad_ab) ctrl_o.op = gdfw_pkg::OP_BAD;
            else if (stat_i.full) ctrl_o.op = gdfw_pkg::OP_FULL;
            else ctrl_o.op = gdfw_pkg::OP_ADD_A;
          end
          gdfw_pkg::CMD_SEARCH: begin
            if (stat_i.bad_a) ctrl_o.op = gdfw_pkg::OP_BAD;
            else ctrl_o.op = gdfw_pkg::OP_VISIT_START;
          end
          default: ctrl_o.op = gdfw_pkg::OP_NONE;
        endcase
      end
      gdfw_pkg::S_ADD2: ctrl_o.op = gdfw_pkg::OP_ADD_B;
      gdfw_pkg::S_WALK: begin
        if (stat_i.level_zero) ctrl_o.op = gdfw_pkg::OP_FINISH;
        else if (stat_i.cur_ok) ctrl_o.op = gdfw_pkg::OP_READ;
        else ctrl_o.op = gdfw_pkg::OP_POP;
      end
      gdfw_pkg::S_FETCH: ctrl_o.op = gdfw_pkg::OP_STEP;
      default: ctrl_o.op = gdfw_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_q != gdfw_pkg::S_IDLE);

endmodule

[rtl/core/gdfw_datapath.sv]
module gdfw_datapath #(
  parameter int unsigned MAX_VERTICES = gdfw_pkg::MAX_VERTICES_DEF,
  parameter int unsigned NODE_SLOTS   = gdfw_pkg::NODE_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gdfw_pkg::cmd_t               cmd_i,
  input  logic                         cfg_we_i,
  input  logic [gdfw_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  gdfw_pkg::ctrl_t              ctrl_i,
  output gdfw_pkg::stat_t              stat_o,
  output logic                         res_valid_o,
  output gdfw_pkg::res_t               res_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned LVW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW  = $clog2(NODE_SLOTS);
  localparam int unsigned LW  = $clog2(NODE_SLOTS + 1);
  localparam int unsigned NW  = gdfw_pkg::VTX_W + LW;

  gdfw_pkg::cmd_t             in_q;
  logic [gdfw_pkg::CFG_W-1:0] vcount_q;
  logic [LW-1:0]              head_q [MAX_VERTICES];
  logic [LW-1:0]              cursor_q [MAX_VERTICES];
  logic [LW-1:0]              used_q;
  logic [MAX_VERTICES-1:0]    visited_q;
  logic [LVW-1:0]             level_q;
  logic [gdfw_pkg::VTX_W-1:0] pend_q;
  logic                       res_valid_q;
  gdfw_pkg::res_t             res_q;

  logic [gdfw_pkg::CNT_W-1:0] limit;
  logic [VW-1:0]              a_idx, b_idx, w_idx, top_idx, lvl_idx;
  logic [LVW-1:0]             top_full;
  logic [LW-1:0]              cur, cur_m1, used_p1;
  logic [LW:0]                used_p2;
  logic                       ram_we;
  logic [NW-1:0]              ram_wdata, ram_rdata;
  logic [gdfw_pkg::VTX_W-1:0] w_vtx;
  logic [LW-1:0]              w_link;
  logic                       take;

  // vertex count clamped to the array size
  always_comb begin
    if ({1'b0, vcount_q} > gdfw_pkg::CNT_W'(MAX_VERTICES)) limit = gdfw_pkg::CNT_W'(MAX_VERTICES);
    else limit = {1'b0, vcount_q};
  end

  assign a_idx    = VW'(in_q.first_vertex);
  assign b_idx    = VW'(in_q.second_vertex);
  assign top_full = level_q - LVW'(1);
  assign top_idx  = top_full[VW-1:0];
  assign lvl_idx  = level_q[VW-1:0];
  assign cur      = cursor_q[top_idx];
  assign cur_m1   = cur - LW'(1);
  assign used_p1  = used_q + LW'(1);
  assign used_p2  = {1'b0, used_q} + (LW+1)'(2);

  assign w_vtx  = ram_rdata[NW-1:LW];
  assign w_link = ram_rdata[LW-1:0];
  assign w_idx  = VW'(w_vtx);
  assign take   = ({2'b00, w_vtx} < limit) && !visited_q[w_idx]
                  && (level_q < LVW'(MAX_VERTICES));

  always_comb begin
    stat_o.cmd        = in_q.command;
    stat_o.bad_a      = ({2'b00, in_q.first_vertex} >= limit);
    stat_o.bad_ab     = stat_o.bad_a || ({2'b00, in_q.second_vertex} >= limit);
    stat_o.full       = (used_p2 > (LW+1)'(NODE_SLOTS));
    stat_o.level_zero = (level_q == '0);
    stat_o.cur_ok     = (cur != '0) && (cur <= used_q);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {in_q.second_vertex, head_q[a_idx]};
    if (ctrl_i.op == gdfw_pkg::OP_ADD_A) begin
      ram_we = 1'b1;
    end else if (ctrl_i.op == gdfw_pkg::OP_ADD_B) begin
      ram_we    = 1'b1;
      ram_wdata = {in_q.first_vertex, head_q[b_idx]};
    end
  end

  gdfw_ram #(
    .WIDTH(NW),
    .DEPTH(NODE_SLOTS)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(used_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(cur_m1[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) in_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= gdfw_pkg::VERTEX_COUNT_RESET;
      used_q      <= '0;
      visited_q   <= '0;
      level_q     <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) head_q[i] <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      unique case (ctrl_i.op)
        gdfw_pkg::OP_CLEAR: begin
          for (int i = 0; i < MAX_VERTICES; i++) head_q[i] <= '0;
          used_q      <= '0;
          res_valid_q <= 1'b1;
        end
        gdfw_pkg::OP_BAD, gdfw_pkg::OP_FULL, gdfw_pkg::OP_FINISH: res_valid_q <= 1'b1;
        gdfw_pkg::OP_ADD_A: begin
          head_q[a_idx] <= used_p1;
          used_q        <= used_p1;
        end
        gdfw_pkg::OP_ADD_B: begin
          head_q[b_idx] <= used_p1;
          used_q        <= used_p1;
          res_valid_q   <= 1'b1;
        end
        gdfw_pkg::OP_VISIT_START: begin
          // only the start vertex stays marked
          visited_q <= MAX_VERTICES'(1) << a_idx;
          level_q   <= LVW'(1);
        end
        gdfw_pkg::OP_POP: level_q <= top_full;
        gdfw_pkg::OP_STEP: begin
          if (take) begin
            visited_q[w_idx] <= 1'b1;
            level_q          <= level_q + LVW'(1);
            res_valid_q      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: cursor stack, pending visit and result
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      gdfw_pkg::OP_CLEAR: res_q <= '{vertex: '0, status: gdfw_pkg::RS_CLEARED, last: 1'b1};
      gdfw_pkg::OP_BAD:   res_q <= '{vertex: '0, status: gdfw_pkg::RS_BAD_VERTEX, last: 1'b1};
      gdfw_pkg::OP_FULL:  res_q <= '{vertex: '0, status: gdfw_pkg::RS_FULL, last: 1'b1};
      gdfw_pkg::OP_ADD_B: res_q <= '{vertex: '0, status: gdfw_pkg::RS_EDGE_ADDED, last: 1'b1};
      gdfw_pkg::OP_FINISH: res_q <= '{vertex: pend_q, status: gdfw_pkg::RS_VISIT, last: 1'b1};
      gdfw_pkg::OP_VISIT_START: begin
        cursor_q[0] <= head_q[a_idx];
        pend_q      <= in_q.first_vertex;
      end
      gdfw_pkg::OP_STEP: begin
        cursor_q[top_idx] <= w_link;
        if (take) begin
          res_q             <= '{vertex: pend_q, status: gdfw_pkg::RS_VISIT, last: 1'b0};
          cursor_q[lvl_idx] <= head_q[w_idx];
          pend_q            <= w_vtx;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[sim/graph_depth_first_walk_unit_test.sv]
`timescale 1ns / 100ps

module graph_depth_first_walk_unit_test;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // golden copy of the graph store and the depth-first walk, kept in step with each transfer
  class walk_scoreboard;
    gdfw_pkg::res_t             pending_results[$];
    int                         errors = 0;
    logic [gdfw_pkg::CFG_W-1:0] vertex_count = gdfw_pkg::VERTEX_COUNT_RESET;
    int                         list_head[gdfw_pkg::MAX_VERTICES_DEF];
    int                         node_vtx[gdfw_pkg::NODE_SLOTS_DEF];
    int                         node_next[gdfw_pkg::NODE_SLOTS_DEF];
    int                         nodes_used = 0;

    function new();
      foreach (list_head[i]) list_head[i] = 0;
    endfunction

    function void prepend(int owner, int value);
      node_vtx[nodes_used]  = value;
      node_next[nodes_used] = list_head[owner];
      list_head[owner]      = nodes_used + 1;
      nodes_used++;
    endfunction

    function gdfw_pkg::res_t make(int v, gdfw_pkg::status_e s);
      gdfw_pkg::res_t r;
      r.vertex = v[gdfw_pkg::VTX_W-1:0];
      r.status = s;
      r.last   = 1'b0;
      return r;
    endfunction

    // works out every result one accepted command causes
    function void note_command(gdfw_pkg::cmd_t c);
      gdfw_pkg::res_t r[$];
      int   n;
      int   a;
      int   b;
      bit   seen[gdfw_pkg::MAX_VERTICES_DEF];
      int   cursor[gdfw_pkg::MAX_VERTICES_DEF];
      int   level;
      int   cur;
      int   w;
      n = (vertex_count > gdfw_pkg::MAX_VERTICES_DEF) ? gdfw_pkg::MAX_VERTICES_DEF : vertex_count;
      a = c.first_vertex;
      b = c.second_vertex;
      case (c.command)
        gdfw_pkg::CMD_CLEAR: begin
          foreach (list_head[i]) list_head[i] = 0;
          nodes_used = 0;
          r.push_back(make(0, gdfw_pkg::RS_CLEARED));
        end
        gdfw_pkg::CMD_ADD: begin
          if (a >= n || b >= n) begin
            r.push_back(make(0, gdfw_pkg::RS_BAD_VERTEX));
          end else if (nodes_used + 2 > gdfw_pkg::NODE_SLOTS_DEF) begin
            r.push_back(make(0, gdfw_pkg::RS_FULL));
          end else begin
            prepend(a, b);
            prepend(b, a);
            r.push_back(make(0, gdfw_pkg::RS_EDGE_ADDED));
          end
        end
        gdfw_pkg::CMD_SEARCH: begin
          if (a >= n) begin
            r.push_back(make(0, gdfw_pkg::RS_BAD_VERTEX));
          end else begin
            foreach (seen[i]) seen[i] = 0;
            // explicit stack of list cursors, one frame per open vertex
            seen[a] = 1;
            r.push_back(make(a, gdfw_pkg::RS_VISIT));
            cursor[0] = list_head[a];
            level = 1;
            while (level > 0) begin
              cur = cursor[level-1];
              if (cur == 0) begin
                level--;
              end else begin
                w = node_vtx[cur-1];
                cursor[level-1] = node_next[cur-1];
                // stale neighbours at or above the count are skipped
                if (w < n && !seen[w]) begin
                  seen[w] = 1;
                  r.push_back(make(w, gdfw_pkg::RS_VISIT));
                  cursor[level] = list_head[w];
                  level++;
                end
              end
            end
          end
        end
        default: return;  // unknown command gives nothing
      endcase
      r[r.size()-1].last = 1'b1;
      foreach (r[i]) pending_results.push_back(r[i]);
    endfunction

    function void check_result(gdfw_pkg::res_t got);
      gdfw_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: vertex %0d status %0d last %0d",
               got.vertex, got.status, got.last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.vertex !== want.vertex) begin
        $error("vertex: expected %0d, actual %0d", want.vertex, got.vertex);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  gdfw_pkg::cmd_t             cmd_i;
  logic                       cfg_we_i;
  logic [gdfw_pkg::CFG_W-1:0] cfg_wdata_i;
  logic                       res_valid_o;
  gdfw_pkg::res_t             res_o;

  walk_scoreboard   walk_sb;
  int               sender_idle_pct;

  graph_depth_first_walk_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // results cannot be held off, so every strobed cycle is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) walk_sb.check_result(res_o);
  end

  // one command transfer; start stays high into the next call unless a gap is drawn
  task automatic send(input logic [1:0] op, input int a, input int b);
    gdfw_pkg::cmd_t c;
    c.command       = op;
    c.first_vertex  = a[gdfw_pkg::VTX_W-1:0];
    c.second_vertex = b[gdfw_pkg::VTX_W-1:0];
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    walk_sb.note_command(c);
  endtask

  // register writes only with the block drained; a trailing unknown command leaves no
  // result to wait on, so the task also waits out its decode before checking busy
  task automatic write_vertex_count(input int value);
    start <= 1'b0;
    @(posedge clk_i);
    while (walk_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[gdfw_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    walk_sb.vertex_count = value[gdfw_pkg::CFG_W-1:0];
  endtask

  // mostly in-range edges and searches so lists grow deep, plus some noise
  task automatic random_command(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) begin
      send(gdfw_pkg::CMD_ADD, $urandom_range(0, n-1), $urandom_range(0, n-1));
    end else if (r < 80) begin
      send(gdfw_pkg::CMD_SEARCH, $urandom_range(0, n-1), $urandom_range(0, 31));
    end else if (r < 84) begin
      send(gdfw_pkg::CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
    end else if (r < 89) begin
      send(CMD_UNKNOWN, $urandom_range(0, 31), $urandom_range(0, 31));
    end else if (r < 95) begin
      send(gdfw_pkg::CMD_ADD, $urandom_range(0, 31), $urandom_range(0, 31));
    end else begin
      send(gdfw_pkg::CMD_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31));
    end
  endtask

  initial begin
    int counts[6];
    int n;
    walk_sb         = new();
    sender_idle_pct = 0;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph, self loop, field extremes, unknown command, clear
    send(gdfw_pkg::CMD_SEARCH, 0, 31);
    send(gdfw_pkg::CMD_ADD, 0, 0);
    send(gdfw_pkg::CMD_ADD, 0, 31);
    send(gdfw_pkg::CMD_ADD, 31, 5);
    send(gdfw_pkg::CMD_ADD, 5, 0);
    send(gdfw_pkg::CMD_SEARCH, 0, 0);
    send(gdfw_pkg::CMD_SEARCH, 31, 0);
    send(CMD_UNKNOWN, 31, 31);
    send(gdfw_pkg::CMD_CLEAR, 31, 31);
    send(gdfw_pkg::CMD_SEARCH, 31, 0);
    // count zero rejects everything
    write_vertex_count(0);
    send(gdfw_pkg::CMD_ADD, 0, 0);
    send(gdfw_pkg::CMD_SEARCH, 0, 0);
    // count above the vertex range acts as full range
    write_vertex_count(63);
    send(gdfw_pkg::CMD_ADD, 31, 31);
    send(gdfw_pkg::CMD_ADD, 0, 20);
    send(gdfw_pkg::CMD_ADD, 20, 3);
    send(gdfw_pkg::CMD_SEARCH, 31, 0);
    // stale neighbours after lowering the count
    write_vertex_count(10);
    send(gdfw_pkg::CMD_SEARCH, 0, 0);
    send(gdfw_pkg::CMD_ADD, 0, 10);
    send(gdfw_pkg::CMD_SEARCH, 20, 0);
    write_vertex_count(1);
    send(gdfw_pkg::CMD_SEARCH, 0, 0);
    send(gdfw_pkg::CMD_ADD, 0, 1);
    send(gdfw_pkg::CMD_CLEAR, 0, 0);

    // random phases: no idling, sender idling 64, a dense fill with count 8, sender idling 22
    counts = '{32, 63, 1, 2, 8, 16};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       sender_idle_pct = 64;
        3:       sender_idle_pct = 22;
        default: sender_idle_pct = 0;
      endcase
      write_vertex_count(phase == 2 ? 8 : counts[$urandom_range(0, 5)]);
      n = (walk_sb.vertex_count > 32) ? 32 : walk_sb.vertex_count;
      if (n == 0) n = 1;
      if (phase == 2) begin
        // fill the node memory past its limit, then walk the dense graph
        send(gdfw_pkg::CMD_CLEAR, 0, 0);
        repeat (132) send(gdfw_pkg::CMD_ADD, $urandom_range(0, 7), $urandom_range(0, 7));
        repeat (4) send(gdfw_pkg::CMD_SEARCH, $urandom_range(0, 7), 0);
      end else begin
        repeat (15) random_command(n);
      end
    end
    write_vertex_count(32);
    repeat (10) random_command(32);

    start <= 1'b0;
    while (walk_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (walk_sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
